@@ rtl/rinse_cycle_sequencer_defines.svh @@
// Assertion macros for the rinse cycle sequencer.
// RCS_ASSERT checks a property on the rising clock edge, off while reset is high.
// RCS_ASSERT_ALWAYS checks a property on the rising clock edge, reset included.
`ifndef RINSE_CYCLE_SEQUENCER_DEFINES_SVH
`define RINSE_CYCLE_SEQUENCER_DEFINES_SVH

`ifndef SYNTH
`define RCS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rinse cycle sequencer assertion failed");
`define RCS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rinse cycle sequencer assertion failed");
`else
`define RCS_ASSERT(label, clk, rst, prop)
`define RCS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ rtl/rcs_pkg.sv @@
package rcs_pkg;

   // Register and field widths
   localparam int REG_W          = 24;
   localparam int CSR_IDX_W      = 3;
   localparam int TIMER_BITS_DEF = 25;
   localparam int MIN_W          = 7;
   localparam int SEC_W          = 6;
   localparam int SECS_W         = 15;   // whole seconds of a 24 bit millisecond count
   localparam int MINF_W         = 9;    // whole minutes of a 24 bit millisecond count

   // Time units
   localparam int MS_PER_S  = 1000;
   localparam int S_PER_MIN = 60;
   localparam int MAX_MIN   = 100;

   // Reciprocals for the constant divides, exact over the value ranges above
   localparam int SHIFT_MS    = 34;
   localparam int RECIP_MS_W  = 25;
   localparam logic [RECIP_MS_W-1:0] RECIP_MS =
      RECIP_MS_W'(((64'd1 << SHIFT_MS) + MS_PER_S - 1) / MS_PER_S);
   localparam int SHIFT_S     = 20;
   localparam int RECIP_S_W   = 15;
   localparam logic [RECIP_S_W-1:0] RECIP_S =
      RECIP_S_W'(((64'd1 << SHIFT_S) + S_PER_MIN - 1) / S_PER_MIN);

   // Configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_GAP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREHEAT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RINSE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RINSE_DRY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PURGE     = 3'd4;

   localparam logic [REG_W-1:0] GAP_RST       = 24'd2000;
   localparam logic [REG_W-1:0] PREHEAT_RST   = 24'd60000;
   localparam logic [REG_W-1:0] RINSE_RST     = 24'd300000;
   localparam logic [REG_W-1:0] RINSE_DRY_RST = 24'd600000;
   localparam logic [REG_W-1:0] PURGE_RST     = 24'd30000;

   typedef enum logic [2:0] {
      KIND_TICK       = 3'd0,
      KIND_START      = 3'd1,
      KIND_PAUSE      = 3'd2,
      KIND_RESUME     = 3'd3,
      KIND_RESET_DONE = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      PH_WAIT         = 4'd0,
      PH_PREHEAT      = 4'd1,
      PH_FILL         = 4'd2,
      PH_PAUSED       = 4'd3,
      PH_SETTLE_FILL  = 4'd4,
      PH_RINSE        = 4'd5,
      PH_PURGE        = 4'd6,
      PH_SETTLE_PURGE = 4'd7,
      PH_FINAL        = 4'd8,
      PH_DONE         = 4'd9
   } phase_type;

   // What a request does to the remaining time display
   typedef enum logic [1:0] {
      DISP_KEEP  = 2'd0,
      DISP_LOAD  = 2'd1,
      DISP_BLANK = 2'd2
   } disp_op_type;

   // Sequencer state after one request, plus its display update
   typedef struct packed {
      phase_type         phase;
      logic              drying;
      logic              void_on;
      logic              milk_on;
      logic              cold_water_on;
      logic              hot_water_on;
      disp_op_type       op;
      logic [REG_W-1:0]  remain;
   } stage_type;

   // Result item, highest field first so that it packs from phase upward
   typedef struct packed {
      logic [SEC_W-1:0]  seconds;
      logic [MIN_W-1:0]  minutes;
      logic              shown;
      logic              hot_water_on;
      logic              cold_water_on;
      logic              milk_on;
      logic              void_on;
      logic              drying;
      phase_type         phase;
   } result_type;

endpackage

@@ rtl/rcs_display.sv @@
`include "rinse_cycle_sequencer_defines.svh"

module rcs_display (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                item_valid,
   input  rcs_pkg::stage_type  item,
   output logic                rsp_valid,
   output rcs_pkg::result_type rsp_item
);
   import rcs_pkg::*;

   localparam int PROD_MS_W = REG_W + RECIP_MS_W;
   localparam int PROD_S_W  = SECS_W + RECIP_S_W;

   logic                 v2_ff;
   stage_type            item2_ff;
   logic [SECS_W-1:0]    secs_ff;
   logic [PROD_MS_W-1:0] prod_ms;
   logic [PROD_S_W-1:0]  prod_s;
   logic [MINF_W-1:0]    min_full;
   logic [SECS_W-1:0]    sec_full;
   logic                 in_range;
   logic                 v3_ff;
   result_type           res_ff;
   result_type           res_in;

   // Whole seconds of the remaining milliseconds
   assign prod_ms = PROD_MS_W'(item.remain) * PROD_MS_W'(RECIP_MS);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= item_valid;
      end
      if (advance) begin
         item2_ff <= item;
         secs_ff  <= prod_ms[SHIFT_MS +: SECS_W];
      end
   end

   // Split seconds into minutes and leftover seconds
   assign prod_s   = PROD_S_W'(secs_ff) * PROD_S_W'(RECIP_S);
   assign min_full = prod_s[SHIFT_S +: MINF_W];
   assign sec_full = secs_ff - SECS_W'(min_full) * SECS_W'(S_PER_MIN);
   assign in_range = min_full <= MINF_W'(MAX_MIN);

   // Apply the display update; the held fields are the display state
   always_comb begin
      res_in               = res_ff;
      res_in.phase         = item2_ff.phase;
      res_in.drying        = item2_ff.drying;
      res_in.void_on       = item2_ff.void_on;
      res_in.milk_on       = item2_ff.milk_on;
      res_in.cold_water_on = item2_ff.cold_water_on;
      res_in.hot_water_on  = item2_ff.hot_water_on;
      unique case (item2_ff.op)
         DISP_LOAD: begin
            if (in_range) begin
               res_in.shown   = 1'b1;
               res_in.minutes = min_full[MIN_W-1:0];
               res_in.seconds = sec_full[SEC_W-1:0];
            end
         end
         DISP_BLANK: begin
            res_in.shown = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff  <= 1'b0;
         res_ff <= '0;
      end else if (advance) begin
         v3_ff <= v2_ff;
         if (v2_ff) begin
            res_ff <= res_in;
         end
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_item  = res_ff;

   `RCS_ASSERT(a_shown_range, clock, reset,
      res_ff.shown |-> (res_ff.minutes <= MIN_W'(MAX_MIN)) && (res_ff.seconds < SEC_W'(S_PER_MIN)))
   `RCS_ASSERT(a_blank_clears, clock, reset,
      (advance && v2_ff && item2_ff.op == DISP_BLANK) |=> !res_ff.shown)
   `RCS_ASSERT(a_hold_on_stall, clock, reset,
      (!advance) |=> $stable(res_ff) && $stable(v2_ff))

endmodule

@@ rtl/rinse_cycle_sequencer.sv @@
// Channel  Dir  Handshake             Payload
// req      in   req_tvalid/tready     tuser: kind; tdata: preheat, drying, level
// rsp      out  rsp_tvalid/tready     tdata: phase, latches, display
// csr      in   csr_valid/csr_ready   csr_index, csr_data (always ready)
//
// One request is accepted per cycle while the response side is not stalled; its response
// becomes valid after the request passes the input register, then the sequencer step, the
// seconds divide, and the minutes split with display.
// The seconds divide and the minutes split hold the two reciprocal multiplies of the time display.
// A waiting response with rsp_tready low freezes the whole pipeline and drops
// req_tready with it.
// Reset is synchronous: state returns to waiting, registers to their defaults.
`include "rinse_cycle_sequencer_defines.svh"

module rinse_cycle_sequencer #(
   parameter int TIMER_BITS = rcs_pkg::TIMER_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // preheat_req, drying_req, level_reached
   input  logic [2:0]                     req_tuser,   // kind
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // phase[3:0], drying_mode, void_pump_on, milk_pump_on, cold_water_on,
   // hot_water_on, remain_shown, remain_minutes[16:10], remain_seconds[22:17]
   output logic [23:0]                    rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcs_pkg::REG_W-1:0]      csr_data
);
   import rcs_pkg::*;

   localparam int CMP_W = (TIMER_BITS > REG_W) ? TIMER_BITS : REG_W;

   logic [REG_W-1:0]      gap_ff, preheat_ff, rinse_ff, rinse_dry_ff, purge_ff;
   logic                  advance;
   logic                  fire0;
   logic                  v0_ff;
   logic [2:0]            kind_ff;
   logic                  preheat_req_ff, drying_req_ff, level_ff;
   logic                  v1_ff;
   stage_type             s1_ff;
   stage_type             s1_in;
   logic [TIMER_BITS-1:0] elapsed_ff;
   logic [TIMER_BITS-1:0] elapsed_in;
   logic [TIMER_BITS-1:0] elapsed_inc;
   logic [REG_W-1:0]      dur;
   logic [CMP_W-1:0]      remain_full;
   logic                  over;
   logic                  rsp_valid;
   result_type            rsp_item;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff       <= GAP_RST;
         preheat_ff   <= PREHEAT_RST;
         rinse_ff     <= RINSE_RST;
         rinse_dry_ff <= RINSE_DRY_RST;
         purge_ff     <= PURGE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GAP:       gap_ff       <= csr_data;
            CSR_PREHEAT:   preheat_ff   <= csr_data;
            CSR_RINSE:     rinse_ff     <= csr_data;
            CSR_RINSE_DRY: rinse_dry_ff <= csr_data;
            CSR_PURGE:     purge_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Advance the pipeline whenever the response slot frees up
   assign advance    = !rsp_valid || rsp_tready;
   assign req_tready = advance;
   assign fire0      = v0_ff && advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_tvalid;
      end
      if (advance && req_tvalid) begin
         kind_ff        <= req_tuser;
         preheat_req_ff <= req_tdata[0];
         drying_req_ff  <= req_tdata[1];
         level_ff       <= req_tdata[2];
      end
   end

   // Timer step and the duration of the current phase
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + TIMER_BITS'(1);

   always_comb begin
      unique case (s1_ff.phase)
         PH_PREHEAT: dur = preheat_ff;
         PH_RINSE:   dur = s1_ff.drying ? rinse_dry_ff : rinse_ff;
         PH_PURGE:   dur = purge_ff;
         default:    dur = gap_ff;
      endcase
   end

   assign over        = CMP_W'(elapsed_inc) > CMP_W'(dur);
   assign remain_full = CMP_W'(dur) - CMP_W'(elapsed_inc);

   // Sequencer step for one request
   always_comb begin
      s1_in        = s1_ff;
      s1_in.op     = DISP_KEEP;
      s1_in.remain = remain_full[REG_W-1:0];
      elapsed_in   = elapsed_ff;
      unique case (kind_ff)
         KIND_TICK: begin
            elapsed_in = elapsed_inc;
            unique case (s1_ff.phase)
               PH_PREHEAT: begin
                  s1_in.op           = over ? DISP_KEEP : DISP_LOAD;
                  s1_in.hot_water_on = !over;
                  if (over) begin
                     s1_in.phase = PH_FILL;
                     elapsed_in  = '0;
                  end
               end
               PH_FILL: begin
                  s1_in.op            = DISP_BLANK;
                  s1_in.cold_water_on = 1'b1;
                  if (level_ff) begin
                     s1_in.cold_water_on = 1'b0;
                     s1_in.hot_water_on  = 1'b0;
                     s1_in.phase         = PH_SETTLE_FILL;
                     elapsed_in          = '0;
                  end
               end
               PH_PAUSED: begin
                  s1_in.cold_water_on = 1'b0;
                  s1_in.hot_water_on  = 1'b0;
               end
               PH_SETTLE_FILL: begin
                  if (over) begin
                     s1_in.phase = PH_RINSE;
                     elapsed_in  = '0;
                  end
               end
               PH_RINSE: begin
                  s1_in.op      = over ? DISP_KEEP : DISP_LOAD;
                  s1_in.void_on = 1'b1;
                  if (over) begin
                     s1_in.phase = PH_PURGE;
                     elapsed_in  = '0;
                  end
               end
               PH_PURGE: begin
                  s1_in.op      = over ? DISP_KEEP : DISP_LOAD;
                  s1_in.milk_on = !over;
                  if (over) begin
                     s1_in.phase = PH_SETTLE_PURGE;
                     elapsed_in  = '0;
                  end
               end
               PH_SETTLE_PURGE: begin
                  if (over) begin
                     s1_in.void_on = 1'b0;
                     s1_in.phase   = PH_FINAL;
                     elapsed_in    = '0;
                  end
               end
               PH_FINAL: begin
                  if (over) begin
                     s1_in.phase = PH_DONE;
                     elapsed_in  = '0;
                  end
               end
               default: begin
               end
            endcase
         end
         KIND_START: begin
            s1_in.drying = drying_req_ff;
            s1_in.phase  = preheat_req_ff ? PH_PREHEAT : PH_FILL;
            elapsed_in   = '0;
         end
         KIND_PAUSE: begin
            if (s1_ff.phase == PH_FILL) s1_in.phase = PH_PAUSED;
         end
         KIND_RESUME: begin
            if (s1_ff.phase == PH_PAUSED) s1_in.phase = PH_FILL;
         end
         KIND_RESET_DONE: begin
            if (s1_ff.phase == PH_DONE) s1_in.phase = PH_WAIT;
         end
         default: begin
         end
      endcase
   end

   // Sequencer state register, which also carries the request downstream
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         s1_ff      <= '0;
         elapsed_ff <= '0;
      end else begin
         if (advance) begin
            v1_ff <= v0_ff;
         end
         if (fire0) begin
            s1_ff      <= s1_in;
            elapsed_ff <= elapsed_in;
         end
      end
   end

   rcs_display u_display (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item_valid (v1_ff),
      .item       (s1_ff),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {1'b0, rsp_item};

   `RCS_ASSERT(a_start_restarts, clock, reset,
      (fire0 && kind_ff == KIND_START) |=> (elapsed_ff == '0) &&
      (s1_ff.phase == PH_PREHEAT || s1_ff.phase == PH_FILL))
   `RCS_ASSERT(a_drying_on_start_only, clock, reset,
      !(fire0 && kind_ff == KIND_START) |=> $stable(s1_ff.drying))
   `RCS_ASSERT(a_paused_valves_off, clock, reset,
      (fire0 && kind_ff == KIND_TICK && s1_ff.phase == PH_PAUSED) |=>
      (!s1_ff.cold_water_on && !s1_ff.hot_water_on))

endmodule

@@ tb/rinse_cycle_sequencer_tb.sv @@
`timescale 1ns / 100ps

module rinse_cycle_sequencer_tb;
   import rcs_pkg::*;

   localparam int LATENCY = 4;

   // Track the sequencer state and queue the responses it should give
   class rinse_scoreboard;
      logic [REG_W-1:0]          gap_len, preheat_len, rinse_len, rinse_dry_len, purge_len;
      phase_type                 phase;
      logic [TIMER_BITS_DEF-1:0] elapsed;
      logic                      drying, void_on, milk_on, cold_on, hot_on, shown;
      logic [MIN_W-1:0]          minutes;
      logic [SEC_W-1:0]          seconds;
      result_type                pending_q[$];
      int                        errors;

      function new();
         gap_len       = GAP_RST;
         preheat_len   = PREHEAT_RST;
         rinse_len     = RINSE_RST;
         rinse_dry_len = RINSE_DRY_RST;
         purge_len     = PURGE_RST;
         phase         = PH_WAIT;
         elapsed       = '0;
         drying        = 1'b0;
         void_on       = 1'b0;
         milk_on       = 1'b0;
         cold_on       = 1'b0;
         hot_on        = 1'b0;
         shown         = 1'b0;
         minutes       = '0;
         seconds       = '0;
         errors        = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] val);
         case (idx)
            CSR_GAP:       gap_len = val;
            CSR_PREHEAT:   preheat_len = val;
            CSR_RINSE:     rinse_len = val;
            CSR_RINSE_DRY: rinse_dry_len = val;
            CSR_PURGE:     purge_len = val;
            default: ;
         endcase
      endfunction

      function void enter_phase(phase_type ph);
         phase   = ph;
         elapsed = '0;
      endfunction

      // Load the display unless the time is past or too long to show
      function void load_remaining(logic [REG_W-1:0] dur);
         longint unsigned left, mins, secs;
         if (elapsed > dur) return;
         left = dur - elapsed;
         mins = left / (MS_PER_S * S_PER_MIN);
         secs = (left % (MS_PER_S * S_PER_MIN)) / MS_PER_S;
         if (mins > MAX_MIN) return;
         shown   = 1'b1;
         minutes = mins[MIN_W-1:0];
         seconds = secs[SEC_W-1:0];
      endfunction

      function void advance_tick(logic level);
         logic [REG_W-1:0] dur;
         if (elapsed != '1) elapsed = elapsed + 1'b1;
         case (phase)
            PH_PREHEAT: begin
               load_remaining(preheat_len);
               hot_on = 1'b1;
               if (elapsed > preheat_len) begin
                  hot_on = 1'b0;
                  enter_phase(PH_FILL);
               end
            end
            PH_FILL: begin
               shown   = 1'b0;
               cold_on = 1'b1;
               if (level) begin
                  cold_on = 1'b0;
                  hot_on  = 1'b0;
                  enter_phase(PH_SETTLE_FILL);
               end
            end
            PH_PAUSED: begin
               cold_on = 1'b0;
               hot_on  = 1'b0;
            end
            PH_SETTLE_FILL: begin
               if (elapsed > gap_len) enter_phase(PH_RINSE);
            end
            PH_RINSE: begin
               dur = drying ? rinse_dry_len : rinse_len;
               load_remaining(dur);
               void_on = 1'b1;
               if (elapsed > dur) enter_phase(PH_PURGE);
            end
            PH_PURGE: begin
               load_remaining(purge_len);
               milk_on = 1'b1;
               if (elapsed > purge_len) begin
                  milk_on = 1'b0;
                  enter_phase(PH_SETTLE_PURGE);
               end
            end
            PH_SETTLE_PURGE: begin
               if (elapsed > gap_len) begin
                  void_on = 1'b0;
                  enter_phase(PH_FINAL);
               end
            end
            PH_FINAL: begin
               if (elapsed > gap_len) enter_phase(PH_DONE);
            end
            default: ;
         endcase
      endfunction

      // Step the state on an accepted request and queue the response
      function void note_request(logic [2:0] kind, logic pre, logic dry, logic lvl);
         result_type want;
         case (kind)
            KIND_TICK: advance_tick(lvl);
            KIND_START: begin
               drying = dry;
               enter_phase(pre ? PH_PREHEAT : PH_FILL);
            end
            KIND_PAUSE:      if (phase == PH_FILL) phase = PH_PAUSED;
            KIND_RESUME:     if (phase == PH_PAUSED) phase = PH_FILL;
            KIND_RESET_DONE: if (phase == PH_DONE) phase = PH_WAIT;
            default: ;
         endcase
         want.phase         = phase;
         want.drying        = drying;
         want.void_on       = void_on;
         want.milk_on       = milk_on;
         want.cold_water_on = cold_on;
         want.hot_water_on  = hot_on;
         want.shown         = shown;
         want.minutes       = minutes;
         want.seconds       = seconds;
         pending_q.push_back(want);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(logic [23:0] data);
         result_type want, got;
         got = result_type'(data[22:0]);
         if (pending_q.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, expected none, actual %h", $time, data);
            return;
         end
         want = pending_q.pop_front();
         compare_field("phase", 8'(want.phase), 8'(got.phase));
         compare_field("drying_mode", 8'(want.drying), 8'(got.drying));
         compare_field("void_pump_on", 8'(want.void_on), 8'(got.void_on));
         compare_field("milk_pump_on", 8'(want.milk_on), 8'(got.milk_on));
         compare_field("cold_water_on", 8'(want.cold_water_on), 8'(got.cold_water_on));
         compare_field("hot_water_on", 8'(want.hot_water_on), 8'(got.hot_water_on));
         compare_field("remain_shown", 8'(want.shown), 8'(got.shown));
         compare_field("remain_minutes", 8'(want.minutes), 8'(got.minutes));
         compare_field("remain_seconds", 8'(want.seconds), 8'(got.seconds));
         compare_field("padding", 8'd0, 8'(data[23]));
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // preheat_req, drying_req, level_reached
   logic [2:0]            req_tuser = '0;   // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // phase[3:0], drying_mode, void_pump_on, milk_pump_on, cold_water_on,
   // hot_water_on, remain_shown, remain_minutes[16:10], remain_seconds[22:17]
   logic [23:0]           rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [REG_W-1:0]      csr_data = '0;

   logic                  steady = 1'b0;
   rinse_scoreboard       sb;

   rinse_cycle_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Stall the response side now and then
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 8);
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   // Offer one request, idling at random first, and log it once accepted
   task automatic send_req(logic [2:0] kind, logic pre, logic dry, logic lvl);
      while (!steady && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, lvl, dry, pre};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, pre, dry, lvl);
   endtask

   // Hold requests until every response is back and the pipeline is empty
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_regs(logic [REG_W-1:0] gap, logic [REG_W-1:0] preheat,
                             logic [REG_W-1:0] rinse, logic [REG_W-1:0] rinse_dry,
                             logic [REG_W-1:0] purge);
      logic [CSR_IDX_W-1:0] idx [5];
      logic [REG_W-1:0]     val [5];
      idx = '{CSR_GAP, CSR_PREHEAT, CSR_RINSE, CSR_RINSE_DRY, CSR_PURGE};
      val = '{gap, preheat, rinse, rinse_dry, purge};
      drain();
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
         sb.set_register(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [REG_W-1:0] pick_duration();
      if ($urandom_range(1) == 0) return REG_W'($urandom_range(40));
      return REG_W'($urandom);
   endfunction

   function automatic logic [REG_W-1:0] short_duration();
      return REG_W'($urandom_range(30, 1));
   endfunction

   function automatic logic coin();
      return 1'($urandom_range(1));
   endfunction

   // Mostly well-formed wash cycles with random content, some noise
   task automatic run_random(int count);
      int sent;
      int roll;
      int cap;
      sent = 0;
      cap  = $urandom_range(80, 20);
      while (sent < count) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            send_req(3'($urandom_range(7)), coin(), coin(), coin());
         end else begin
            case (sb.phase)
               PH_WAIT: begin
                  if (roll < 70) send_req(KIND_START, coin(), coin(), coin());
                  else send_req(KIND_TICK, coin(), coin(), coin());
               end
               PH_FILL: begin
                  if (roll < 12) send_req(KIND_PAUSE, coin(), coin(), coin());
                  else if (roll < 15) send_req(KIND_START, coin(), coin(), coin());
                  else send_req(KIND_TICK, coin(), coin(), $urandom_range(7) == 0);
               end
               PH_PAUSED: begin
                  if (roll < 40) send_req(KIND_RESUME, coin(), coin(), coin());
                  else if (roll < 45) send_req(KIND_START, coin(), coin(), coin());
                  else send_req(KIND_TICK, coin(), coin(), coin());
               end
               PH_DONE: begin
                  if (roll < 50) send_req(KIND_RESET_DONE, coin(), coin(), coin());
                  else if (roll < 55) send_req(KIND_START, coin(), coin(), coin());
                  else send_req(KIND_TICK, coin(), coin(), coin());
               end
               default: begin
                  // restart a timed phase that would run too long
                  if (sb.elapsed > cap || roll < 5) begin
                     send_req(KIND_START, coin(), coin(), coin());
                     cap = $urandom_range(80, 20);
                  end else if (roll < 9) begin
                     send_req(coin() ? KIND_PAUSE : KIND_RESUME, coin(), coin(), coin());
                  end else if (roll < 11) begin
                     send_req(KIND_RESET_DONE, coin(), coin(), coin());
                  end else begin
                     send_req(KIND_TICK, coin(), coin(), coin());
                  end
               end
            endcase
         end
         sent++;
      end
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Commands out of place, then preheat, fill, pause and resume
      send_req(KIND_TICK, 1'b0, 1'b0, 1'b1);
      send_req(KIND_PAUSE, 1'b1, 1'b1, 1'b1);
      send_req(KIND_RESUME, 1'b0, 1'b0, 1'b0);
      send_req(KIND_RESET_DONE, 1'b0, 1'b0, 1'b0);
      send_req(3'd5, 1'b1, 1'b0, 1'b1);
      send_req(3'd7, 1'b0, 1'b1, 1'b0);
      send_req(KIND_START, 1'b1, 1'b1, 1'b0);
      repeat (3) send_req(KIND_TICK, 1'b0, 1'b0, 1'b1);
      send_req(KIND_PAUSE, 1'b0, 1'b0, 1'b0);
      send_req(KIND_START, 1'b0, 1'b0, 1'b0);
      send_req(KIND_TICK, 1'b0, 1'b0, 1'b0);
      send_req(KIND_PAUSE, 1'b0, 1'b0, 1'b0);
      send_req(KIND_TICK, 1'b1, 1'b1, 1'b1);
      send_req(KIND_PAUSE, 1'b0, 1'b0, 1'b0);
      send_req(KIND_RESUME, 1'b0, 1'b0, 1'b0);
      send_req(KIND_TICK, 1'b0, 1'b0, 1'b1);
      repeat (2) send_req(KIND_TICK, 1'b0, 1'b0, 1'b0);
      run_random(60);

      // Zero durations: run a whole cycle through done and back to waiting
      write_regs('0, '0, '0, '0, '0);
      send_req(KIND_START, 1'b1, 1'b0, 1'b0);
      while (sb.phase != PH_DONE) send_req(KIND_TICK, 1'b0, 1'b0, 1'b1);
      send_req(KIND_TICK, 1'b0, 1'b0, 1'b0);
      send_req(KIND_RESET_DONE, 1'b0, 1'b0, 1'b0);
      run_random(150);

      // Short durations with no idling on either side
      write_regs(short_duration(), short_duration(), short_duration(),
                 short_duration(), short_duration());
      steady = 1'b1;
      run_random(250);
      steady = 1'b0;

      // Durations around the largest time the display can show
      write_regs(24'd3, 24'd6060001, 24'd6059999, '1, 24'd60000);
      run_random(120);

      write_regs('1, '1, '1, '1, '1);
      run_random(40);

      write_regs(pick_duration(), pick_duration(), pick_duration(),
                 pick_duration(), pick_duration());
      run_random(150);

      write_regs(short_duration(), short_duration(), short_duration(),
                 short_duration(), short_duration());
      run_random(160);

      drain();
      repeat (LATENCY * 2) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("rinse_cycle_sequencer regression: pass");
      end else begin
         $display("rinse_cycle_sequencer regression: fail");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #4000000;
      $display("rinse_cycle_sequencer regression: fail");
      $finish;
   end

endmodule
